[hdl/mandelbrot_escape_time_assert.svh]
// Assertion macros shared by the queue and iterator modules of the escape-time engine.
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

`ifndef SYNTHESIS

`define MBE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define MBE_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define MBE_ASSERT(lbl, clk, rst_n, prop)

`define MBE_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[hdl/mbe_pkg.sv]
// Shared types, constants and helper functions of the escape-time engine.
`default_nettype none

package mbe_pkg;

    localparam int FRAC_BITS_DEF  = 28;
    localparam int COORD_BITS_DEF = 12;
    localparam int DATA_W         = 32;
    localparam int CNT_W          = 16;
    localparam int CFG_AW         = 5;
    localparam int QUEUE_DEPTH    = 2;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_ORIGIN_REAL = 3'd0;
    localparam t_reg_idx REG_ORIGIN_IMAG = 3'd1;
    localparam t_reg_idx REG_STEP_REAL   = 3'd2;
    localparam t_reg_idx REG_STEP_IMAG   = 3'd3;
    localparam t_reg_idx REG_MAX_ITER    = 3'd4;

    localparam logic signed [DATA_W-1:0] RST_ORIGIN_REAL = -32'sd536870912;
    localparam logic signed [DATA_W-1:0] RST_ORIGIN_IMAG = -32'sd268435456;
    localparam logic signed [DATA_W-1:0] RST_STEP_REAL   = 32'sd196608;
    localparam logic signed [DATA_W-1:0] RST_STEP_IMAG   = 32'sd196608;
    localparam logic [CNT_W-1:0]         RST_MAX_ITER    = 16'd255;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_real;
        logic signed [DATA_W-1:0] origin_imag;
        logic signed [DATA_W-1:0] step_real;
        logic signed [DATA_W-1:0] step_imag;
        logic [CNT_W-1:0]         iter_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] c_re;
        logic signed [DATA_W-1:0] c_im;
    } t_point;

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'(S32_MAX)) begin
            return S32_MAX;
        end else if (v < 66'(S32_MIN)) begin
            return S32_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/mbe_fifo.sv]
// Small first-in first-out queue built from flip-flops.
`default_nettype none
`include "mandelbrot_escape_time_assert.svh"

module mbe_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `MBE_NEVER(a_fifo_overfill, i_clk, i_rst_n, r_count > CW'(DEPTH))
    `MBE_ASSERT(a_fifo_grow, i_clk, i_rst_n, (w_do_push && !w_do_pop) |=> (r_count == $past(r_count) + CW'(1)))
    `MBE_ASSERT(a_fifo_shrink, i_clk, i_rst_n, (w_do_pop && !w_do_push) |=> (r_count == $past(r_count) - CW'(1)))

endmodule

`default_nettype wire

[hdl/mbe_front.sv]
// Front end: takes pixel words and maps them to points of the complex plane.
`default_nettype none

module mbe_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mbe_pkg::t_cfg         i_cfg,
    input  wire logic                  i_push,
    input  wire logic [COORD_BITS-1:0] i_pixel_x,
    input  wire logic [COORD_BITS-1:0] i_pixel_y,
    output logic                       o_full,
    output logic                       o_push,
    output mbe_pkg::t_point            o_point,
    input  wire logic                  i_full
);
    import mbe_pkg::*;

    localparam int PW = COORD_BITS + DATA_W + 1;

    logic signed [PW-1:0] r_prod_re;
    logic signed [PW-1:0] r_prod_im;
    logic                 r_v1;
    t_point               r_point;
    logic                 r_v2;
    logic                 w_ld1;
    logic                 w_ld2;
    logic                 w_adv2;

    assign w_adv2  = r_v2 && !i_full;
    assign w_ld2   = r_v1 && (!r_v2 || !i_full);
    assign o_full  = r_v1 && !w_ld2;
    assign w_ld1   = i_push && !o_full;
    assign o_push  = r_v2;
    assign o_point = r_point;

    // Stage one forms the offsets, stage two adds the origin and clamps.
    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_prod_re <= $signed({1'b0, i_pixel_x}) * i_cfg.step_real;
            r_prod_im <= $signed({1'b0, i_pixel_y}) * i_cfg.step_imag;
        end
        if (w_ld2) begin
            r_point.c_re <= sat32(66'(i_cfg.origin_real) + 66'(r_prod_re));
            r_point.c_im <= sat32(66'(i_cfg.origin_imag) + 66'(r_prod_im));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_ld1) begin
                r_v1 <= 1'b1;
            end else if (w_ld2) begin
                r_v1 <= 1'b0;
            end
            if (w_ld2) begin
                r_v2 <= 1'b1;
            end else if (w_adv2) begin
                r_v2 <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/mbe_iter.sv]
// Back end: iterates z = z*z + c for one point and counts the updates.
`default_nettype none
`include "mandelbrot_escape_time_assert.svh"

module mbe_iter #(
    parameter int FRAC_BITS = 28
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [mbe_pkg::CNT_W-1:0] i_max,
    input  wire mbe_pkg::t_point        i_point,
    input  wire logic                   i_empty,
    output logic                        o_pop,
    output logic                        o_push,
    output logic [mbe_pkg::CNT_W-1:0]   o_count,
    input  wire logic                   i_full
);
    import mbe_pkg::*;

    localparam int LIM_SH = 2 * FRAC_BITS + 2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    t_point                   r_c;
    logic signed [DATA_W-1:0] r_zr;
    logic signed [DATA_W-1:0] r_zi;
    logic signed [63:0]       r_sr;
    logic signed [63:0]       r_si;
    logic signed [63:0]       r_pri;
    logic [CNT_W-1:0]         r_n;
    logic                     r_started;
    logic [63:0]              w_sum;
    logic                     w_escape;
    logic                     w_cap;
    logic                     w_stop;
    logic signed [63:0]       w_re_sh;
    logic signed [63:0]       w_im_sh;

    // The squares serve both the escape test and the next real part.
    assign w_sum    = $unsigned(r_sr) + $unsigned(r_si);
    assign w_escape = (w_sum >> LIM_SH) != '0;
    assign w_cap    = r_started && (r_n >= i_max);
    assign w_stop   = w_escape || w_cap;
    assign w_re_sh  = (r_sr - r_si) >>> FRAC_BITS;
    assign w_im_sh  = r_pri >>> (FRAC_BITS - 1);

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_push  = (r_state == ST_DONE);
    assign o_count = r_n;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = w_stop ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (!i_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= 1'b0;
            r_n       <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_started <= 1'b0;
                r_n       <= '0;
            end else if (r_state == ST_UPD && !w_stop) begin
                // The first update leaves the count at zero.
                r_started <= 1'b1;
                if (r_started) begin
                    r_n <= r_n + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_c  <= i_point;
            r_zr <= '0;
            r_zi <= '0;
        end else if (r_state == ST_UPD && !w_stop) begin
            r_zr <= sat32({{2{w_re_sh[63]}}, w_re_sh} + 66'(r_c.c_re));
            r_zi <= sat32({{2{w_im_sh[63]}}, w_im_sh} + 66'(r_c.c_im));
        end
        if (r_state == ST_MUL) begin
            r_sr  <= r_zr * r_zr;
            r_si  <= r_zi * r_zi;
            r_pri <= r_zr * r_zi;
        end
    end

    `MBE_ASSERT(a_mul_then_upd, i_clk, i_rst_n, (r_state == ST_MUL) |=> (r_state == ST_UPD))
    `MBE_ASSERT(a_pop_starts, i_clk, i_rst_n, o_pop |=> (r_state == ST_MUL && !r_started && r_zr == '0 && r_zi == '0))
    `MBE_ASSERT(a_update_marks, i_clk, i_rst_n, (r_state == ST_UPD && !w_stop) |=> (r_started && r_state == ST_MUL))
    `MBE_ASSERT(a_result_leaves, i_clk, i_rst_n, (r_state == ST_DONE && !i_full) |=> (r_state == ST_IDLE))

endmodule

`default_nettype wire

[hdl/mandelbrot_escape_time.sv]
// Top level of the escape-time engine: register file, front end, queues, iterator.
//
//   Port group        Direction  Handshake            Word
//   pixel input       in         push / full          pixel_x, pixel_y
//   escape result     out        pop / empty          escape_count
//   configuration     in/out     APB psel / penable   origin, step, iteration limit
//
// The front end takes a pixel every cycle while full is low and forms c in a product
// register and a sum register. The iterator runs each iteration through a multiply
// state and an update state, and takes a new point only after its result has left.
// Reset is synchronous and active low; it restores the register defaults and empties
// both queues. A full result queue stalls the iterator, which in turn fills the
// point queue and raises full at the input.
`default_nettype none

module mandelbrot_escape_time #(
    parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [COORD_BITS-1:0]         i_pixel_x,
    input  wire logic [COORD_BITS-1:0]         i_pixel_y,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [mbe_pkg::CNT_W-1:0]          o_escape_count,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mbe_pkg::CFG_AW-1:0]    paddr,
    input  wire logic [mbe_pkg::DATA_W-1:0]    pwdata,
    output logic [mbe_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import mbe_pkg::*;

    t_cfg             r_cfg;
    t_reg_idx         w_idx;
    logic             w_wr;
    logic             w_pt_push;
    t_point           w_pt_in;
    logic             w_pt_full;
    logic             w_pt_pop;
    t_point           w_pt_out;
    logic             w_pt_empty;
    logic             w_res_push;
    logic [CNT_W-1:0] w_res_count;
    logic             w_res_full;

    assign pready = 1'b1;
    assign w_idx  = paddr[CFG_AW-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_real <= RST_ORIGIN_REAL;
            r_cfg.origin_imag <= RST_ORIGIN_IMAG;
            r_cfg.step_real   <= RST_STEP_REAL;
            r_cfg.step_imag   <= RST_STEP_IMAG;
            r_cfg.iter_limit  <= RST_MAX_ITER;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ORIGIN_REAL: r_cfg.origin_real <= pwdata;
                REG_ORIGIN_IMAG: r_cfg.origin_imag <= pwdata;
                REG_STEP_REAL:   r_cfg.step_real   <= pwdata;
                REG_STEP_IMAG:   r_cfg.step_imag   <= pwdata;
                REG_MAX_ITER:    r_cfg.iter_limit  <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ORIGIN_REAL: prdata = r_cfg.origin_real;
            REG_ORIGIN_IMAG: prdata = r_cfg.origin_imag;
            REG_STEP_REAL:   prdata = r_cfg.step_real;
            REG_STEP_IMAG:   prdata = r_cfg.step_imag;
            REG_MAX_ITER:    prdata = {{(DATA_W - CNT_W){1'b0}}, r_cfg.iter_limit};
            default:         prdata = '0;
        endcase
    end

    mbe_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_pixel_x(i_pixel_x),
        .i_pixel_y(i_pixel_y),
        .o_full   (full),
        .o_push   (w_pt_push),
        .o_point  (w_pt_in),
        .i_full   (w_pt_full)
    );

    mbe_fifo #(
        .WIDTH($bits(t_point)),
        .DEPTH(QUEUE_DEPTH)
    ) u_point_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_pt_push),
        .i_data (w_pt_in),
        .o_full (w_pt_full),
        .i_pop  (w_pt_pop),
        .o_data (w_pt_out),
        .o_empty(w_pt_empty)
    );

    mbe_iter #(
        .FRAC_BITS(FRAC_BITS)
    ) u_iter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_max  (r_cfg.iter_limit),
        .i_point(w_pt_out),
        .i_empty(w_pt_empty),
        .o_pop  (w_pt_pop),
        .o_push (w_res_push),
        .o_count(w_res_count),
        .i_full (w_res_full)
    );

    mbe_fifo #(
        .WIDTH(CNT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_result_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res_count),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (o_escape_count),
        .o_empty(empty)
    );

endmodule

`default_nettype wire
